FILE: rtl/pdr_pkg.sv
// Package for the planar dead-reckoning integrator.
// Holds payload structs, the CORDIC arctangent table and shared constants.
package pdr_pkg;

    typedef struct packed {
        logic signed [23:0] vel_x;
        logic signed [23:0] vel_y;
        logic signed [31:0] yaw_rate;
        logic [31:0]        time_us;
    } pdr_in_t;

    typedef struct packed {
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic [31:0]        heading;
    } pdr_out_t;

    // Data handed from one CORDIC cell to the next.
    typedef struct packed {
        logic               vld;
        logic signed [39:0] x;
        logic signed [39:0] y;
        logic signed [33:0] z;
    } pdr_cell_t;

    localparam int ANG_TABLE_LEN = 24;
    localparam logic signed [39:0] CORDIC_X0 = 40'sd652032874;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_START,
        ST_ROT,
        ST_MUL,
        ST_MOVE,
        ST_OUT
    } pdr_state_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [33:0] atan_turns(input logic [4:0] i);
        logic signed [33:0] r;
        begin
            case (i)
                5'd0:  r = 34'sd536870912;
                5'd1:  r = 34'sd316933406;
                5'd2:  r = 34'sd167458907;
                5'd3:  r = 34'sd85004756;
                5'd4:  r = 34'sd42667331;
                5'd5:  r = 34'sd21354465;
                5'd6:  r = 34'sd10679838;
                5'd7:  r = 34'sd5340245;
                5'd8:  r = 34'sd2670163;
                5'd9:  r = 34'sd1335087;
                5'd10: r = 34'sd667544;
                5'd11: r = 34'sd333772;
                5'd12: r = 34'sd166886;
                5'd13: r = 34'sd83443;
                5'd14: r = 34'sd41722;
                5'd15: r = 34'sd20861;
                5'd16: r = 34'sd10430;
                5'd17: r = 34'sd5215;
                5'd18: r = 34'sd2608;
                5'd19: r = 34'sd1304;
                5'd20: r = 34'sd652;
                5'd21: r = 34'sd326;
                5'd22: r = 34'sd163;
                5'd23: r = 34'sd81;
                default: r = 34'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

FILE: rtl/pdr_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift and arctangent constant.
// Depends on pdr_pkg for the cell struct and the arctangent table.
module pdr_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pdr_pkg::pdr_cell_t prev,
    output pdr_pkg::pdr_cell_t stage
);
    import pdr_pkg::*;

    localparam logic signed [33:0] ANG = atan_turns(5'(STEP));

    pdr_cell_t cell_reg;
    pdr_cell_t cell_next;
    logic signed [39:0] xs;
    logic signed [39:0] ys;

    // Rotate toward zero residual angle.
    always_comb
    begin
        xs = prev.x >>> STEP;
        ys = prev.y >>> STEP;
        cell_next.vld = prev.vld;
        if (prev.z >= 0)
        begin
            cell_next.x = prev.x - ys;
            cell_next.y = prev.y + xs;
            cell_next.z = prev.z - ANG;
        end
        else
        begin
            cell_next.x = prev.x + ys;
            cell_next.y = prev.y - xs;
            cell_next.z = prev.z + ANG;
        end
    end

    // Stage register; reset clears the valid bit along with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_reg <= '0;
        else
            cell_reg <= cell_next;
    end

    assign stage = cell_reg;
endmodule

FILE: rtl/pdr_cordic_chain.sv
// Row of CORDIC cells producing Q1.15 cosine and sine of a binary angle.
// Depends on pdr_pkg and pdr_cordic_cell.
module pdr_cordic_chain #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [15:0] cos_q15,
    output logic signed [15:0] sin_q15
);
    import pdr_pkg::*;

    pdr_cell_t chain [CORDIC_STEPS+1];
    logic signed [33:0] z0;
    logic flip_in;
    logic [CORDIC_STEPS-1:0] flip_reg;
    logic signed [39:0] xf;
    logic signed [39:0] yf;

    // Fold the angle into the right half plane.
    always_comb
    begin
        z0 = 34'(signed'(angle));
        flip_in = 1'b0;
        if (z0 > 34'sd1073741824)
        begin
            z0 = z0 - 34'sd2147483648;
            flip_in = 1'b1;
        end
        else if (z0 < -34'sd1073741824)
        begin
            z0 = z0 + 34'sd2147483648;
            flip_in = 1'b1;
        end
        chain[0].vld = start;
        chain[0].x = CORDIC_X0;
        chain[0].y = 40'sd0;
        chain[0].z = z0;
    end

    genvar g;
    generate
        for (g = 0; g < CORDIC_STEPS; g++)
        begin : g_cell
            pdr_cordic_cell #(.STEP(g)) u_cell (
                .clk  (clk),
                .rst_n(rst_n),
                .prev (chain[g]),
                .stage(chain[g+1])
            );
        end
    endgenerate

    // Carry the fold flag alongside the cells.
    always_ff @(posedge clk)
    begin
        flip_reg <= {flip_reg[CORDIC_STEPS-2:0], flip_in};
    end

    function automatic logic signed [15:0] to_q15(input logic signed [39:0] v);
        logic signed [39:0] r;
        begin
            r = (v + 40'sd16384) >>> 15;
            if (r > 40'sd32767)
                r = 40'sd32767;
            else if (r < -40'sd32768)
                r = -40'sd32768;
            return r[15:0];
        end
    endfunction

    // Undo the fold and round the chain output.
    always_comb
    begin
        xf = flip_reg[CORDIC_STEPS-1] ? -chain[CORDIC_STEPS].x : chain[CORDIC_STEPS].x;
        yf = flip_reg[CORDIC_STEPS-1] ? -chain[CORDIC_STEPS].y : chain[CORDIC_STEPS].y;
    end

    assign cos_q15 = to_q15(xf);
    assign sin_q15 = to_q15(yf);
    assign done = chain[CORDIC_STEPS].vld;
endmodule

FILE: rtl/planar_dead_reckoning_integrator_unit.sv
// Top level of the planar dead-reckoning integrator.
// Depends on pdr_pkg and pdr_cordic_chain.
//
// Usage: velocity samples enter on the in channel (in_valid/in_ready, payload
// in_data) and one pose per sample leaves on the out channel (out_valid/
// out_ready, payload out_data). The first sample after reset only latches its
// timestamp and returns the held pose.
// One sample is processed at a time; the next is taken only after the previous
// pose has been written to the output register. Each sample passes the heading,
// start, rotate (the CORDIC cell row), multiply, move and output steps in that
// order, and the sequencer then returns to idle.
// The finished pose sits in an output register; a stalled receiver holds it
// there while the next sample is already being integrated, and that sample
// waits only at the final write-back.
// Reset clears the pose, the heading, the timestamp and the started flag.
module planar_dead_reckoning_integrator_unit #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pdr_pkg::pdr_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pdr_pkg::pdr_out_t out_data
);
    import pdr_pkg::*;

    pdr_state_t state_reg, state_next;
    logic [47:0]        heading_reg, heading_next;
    logic [63:0]        world_x_reg, world_x_next;
    logic [63:0]        world_y_reg, world_y_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic               started_reg, started_next;
    pdr_in_t            smp_reg;
    logic signed [31:0] dt_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic signed [40:0] rx_reg, ry_reg;
    logic signed [63:0] mx_reg, my_reg;
    logic               out_valid_reg;
    pdr_out_t           out_reg;

    logic               cordic_start;
    logic               cordic_done;
    logic signed [15:0] cos_w, sin_w;
    logic               accept;
    logic signed [31:0] dt_w;
    logic signed [15:0] dt_hi;
    logic signed [16:0] dt_lo;

    assign accept = in_valid && in_ready;

    pdr_cordic_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cordic_start),
        .angle  (heading_reg[47:16]),
        .done   (cordic_done),
        .cos_q15(cos_w),
        .sin_q15(sin_w)
    );

    // Next-state logic for the sample sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_HEAD;
            ST_HEAD:  state_next = ST_START;
            ST_START: state_next = ST_ROT;
            ST_ROT:   if (cordic_done) state_next = ST_MUL;
            ST_MUL:   state_next = ST_MOVE;
            ST_MOVE:  state_next = ST_OUT;
            ST_OUT:   if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs; the rotation starts once the new heading is registered.
    always_comb
    begin
        in_ready = 1'b0;
        cordic_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_START: cordic_start = 1'b1;
            default: ;
        endcase
    end

    // Signed timestamp difference; zero on the first sample.
    assign dt_w = started_reg ? signed'(in_data.time_us - last_time_reg) : 32'sd0;

    // Signed high half and unsigned low half of dt for the move products.
    assign dt_hi = dt_reg[31:16];
    assign dt_lo = {1'b0, dt_reg[15:0]};

    // Pose state update.
    always_comb
    begin
        heading_next = heading_reg;
        world_x_next = world_x_reg;
        world_y_next = world_y_reg;
        last_time_next = last_time_reg;
        started_next = started_reg;
        if (accept)
        begin
            last_time_next = in_data.time_us;
            started_next = 1'b1;
        end
        if (state_reg == ST_HEAD)
            heading_next = heading_reg + 48'(64'(smp_reg.yaw_rate) * 64'(dt_reg));
        if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
        begin
            world_x_next = world_x_reg + mx_reg;
            world_y_next = world_y_reg + my_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            heading_reg <= '0;
            world_x_reg <= '0;
            world_y_reg <= '0;
            last_time_reg <= '0;
            started_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            heading_reg <= heading_next;
            world_x_reg <= world_x_next;
            world_y_reg <= world_y_next;
            last_time_reg <= last_time_next;
            started_reg <= started_next;
            if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers; the move is round(r*dt / 2^15) with ties upward,
    // built as 2*r*dt_hi plus the rounded r*dt_lo / 2^15.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_reg <= in_data;
            dt_reg <= dt_w;
        end
        if (cordic_done && state_reg == ST_ROT)
        begin
            cos_reg <= cos_w;
            sin_reg <= sin_w;
        end
        if (state_reg == ST_MUL)
        begin
            rx_reg <= 41'(40'(smp_reg.vel_x) * 40'(cos_reg))
                    - 41'(40'(smp_reg.vel_y) * 40'(sin_reg));
            ry_reg <= 41'(40'(smp_reg.vel_x) * 40'(sin_reg))
                    + 41'(40'(smp_reg.vel_y) * 40'(cos_reg));
        end
        if (state_reg == ST_MOVE)
        begin
            mx_reg <= ((64'(rx_reg) * 64'(dt_hi)) <<< 1)
                    + ((64'(rx_reg) * 64'(dt_lo) + 64'sd16384) >>> 15);
            my_reg <= ((64'(ry_reg) * 64'(dt_hi)) <<< 1)
                    + ((64'(ry_reg) * 64'(dt_lo) + 64'sd16384) >>> 15);
        end
        if (state_reg == ST_OUT && (!out_valid_reg || out_ready))
        begin
            out_reg.pos_x <= world_x_reg + mx_reg;
            out_reg.pos_y <= world_y_reg + my_reg;
            out_reg.heading <= heading_reg[47:16];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for planar_dead_reckoning_integrator_unit.
// Depends on pdr_pkg and the integrator RTL; predicts each pose in a scoreboard class.
module testbench;
    import pdr_pkg::*;

    localparam int STEPS = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int LATENCY = STEPS + 6;

    // Integrates velocity samples into expected poses and checks the block output.
    class pose_scoreboard;
        logic [47:0] heading_acc;
        logic [63:0] world_x;
        logic [63:0] world_y;
        logic [31:0] last_time;
        bit          started;
        pdr_out_t    pending[$];
        int          errors;

        function new();
            heading_acc = '0;
            world_x = '0;
            world_y = '0;
            last_time = '0;
            started = 0;
            errors = 0;
        endfunction

        // Arctangent of 2^-i in 2^-32 turn.
        function longint atan_step(int i);
            longint tbl[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
                21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
                166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
                163, 81};
            return tbl[i];
        endfunction

        function longint round_q15(longint v);
            longint r;
            r = (v + 16384) >>> 15;
            if (r > 32767)
                r = 32767;
            if (r < -32768)
                r = -32768;
            return r;
        endfunction

        // Q1.15 cosine and sine of a binary angle by CORDIC rotation.
        function void unit_vector(logic [31:0] ang, output longint c, output longint s);
            longint z;
            longint x;
            longint y;
            longint xs;
            longint ys;
            bit flip;
            z = longint'($signed(ang));
            x = 652032874;
            y = 0;
            flip = 0;
            if (z > (longint'(1) << 30))
            begin
                z -= longint'(1) << 31;
                flip = 1;
            end
            else if (z < -(longint'(1) << 30))
            begin
                z += longint'(1) << 31;
                flip = 1;
            end
            for (int i = 0; i < STEPS && i < 24; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x -= ys;
                    y += xs;
                    z -= atan_step(i);
                end
                else
                begin
                    x += ys;
                    y -= xs;
                    z += atan_step(i);
                end
            end
            if (flip)
            begin
                x = -x;
                y = -y;
            end
            c = round_q15(x);
            s = round_q15(y);
        endfunction

        // Exact round((r * dt) / 2^15) with ties upward, wrapped to 64 bits.
        function logic [63:0] scaled_move(longint r, longint dt);
            logic signed [127:0] p;
            p = (128'(signed'(r)) * 128'(signed'(dt))) + 128'sd16384;
            p = p >>> 15;
            return p[63:0];
        endfunction

        // Notes an accepted sample and queues the pose it should produce.
        function void note_sample(pdr_in_t s);
            longint dt;
            longint c;
            longint sn;
            longint vx;
            longint vy;
            longint rx;
            longint ry;
            logic [31:0] diff;
            pdr_out_t o;
            if (!started)
            begin
                last_time = s.time_us;
                started = 1;
            end
            diff = s.time_us - last_time;
            dt = longint'($signed(diff));
            last_time = s.time_us;
            heading_acc = heading_acc + 48'(longint'(s.yaw_rate) * dt);
            unit_vector(heading_acc[47:16], c, sn);
            vx = longint'(s.vel_x);
            vy = longint'(s.vel_y);
            rx = vx * c - vy * sn;
            ry = vx * sn + vy * c;
            world_x += scaled_move(rx, dt);
            world_y += scaled_move(ry, dt);
            o.pos_x = world_x;
            o.pos_y = world_y;
            o.heading = heading_acc[47:16];
            pending = {pending, o};
        endfunction

        // Compares one pose transaction with the oldest expectation.
        function void check_pose(pdr_out_t a);
            pdr_out_t e;
            if (pending.size() == 0)
            begin
                $error("pose transaction with no expectation waiting");
                errors++;
                return;
            end
            e = pending[0];
            pending.delete(0);
            if (a.pos_x !== e.pos_x)
            begin
                $error("pos_x expected %0d actual %0d", e.pos_x, a.pos_x);
                errors++;
            end
            if (a.pos_y !== e.pos_y)
            begin
                $error("pos_y expected %0d actual %0d", e.pos_y, a.pos_y);
                errors++;
            end
            if (a.heading !== e.heading)
            begin
                $error("heading expected %0h actual %0h", e.heading, a.heading);
                errors++;
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    pdr_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    pdr_out_t out_data;

    pose_scoreboard board;
    bit            sending_done;
    bit            hold_receiver;
    logic [31:0]   clock_us;

    planar_dead_reckoning_integrator_unit #(.CORDIC_STEPS(STEPS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    // Free-running clock.
    initial clk = 0;
    always #5 clk = ~clk;

    // Offers one sample and waits for its transaction.
    task automatic send_sample(pdr_in_t s);
        in_valid <= 1'b1;
        in_data <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_sample(s);
    endtask

    task automatic idle_sender(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    function automatic pdr_in_t make_sample(int vx, int vy, int rate, logic [31:0] t);
        pdr_in_t s;
        s.vel_x = 24'(vx);
        s.vel_y = 24'(vy);
        s.yaw_rate = rate;
        s.time_us = t;
        return s;
    endfunction

    // Random sample: mostly small forward steps, sometimes wide or backward jumps.
    function automatic pdr_in_t random_sample();
        pdr_in_t s;
        logic [31:0] step;
        s.vel_x = 24'($urandom);
        s.vel_y = 24'($urandom);
        s.yaw_rate = $urandom;
        case ($urandom_range(0, 9))
            0: step = $urandom;
            1: step = -32'($urandom_range(1, 100000));
            2: step = 0;
            default: step = $urandom_range(1, 100000);
        endcase
        if ($urandom_range(0, 3) == 0)
            s.vel_x = 24'($signed($urandom_range(0, 4000)) - 2000);
        clock_us += step;
        s.time_us = clock_us;
        return s;
    endfunction

    // Stimulus: directed corners, then random bursts with gaps.
    initial
    begin
        int burst;
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        sending_done = 0;
        clock_us = 32'hFFFF_0000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // First sample, then ordinary motion and a timestamp wrap.
        send_sample(make_sample(1000, 0, 0, 32'hFFFF_0000));
        send_sample(make_sample(1000, 0, 0, 32'hFFFF_8000));
        send_sample(make_sample(-8388608, 8388607, 0, 32'h0000_4000));
        send_sample(make_sample(8388607, -8388608, 32'h7FFF_FFFF, 32'h0001_0000));
        // Backward timestamp.
        send_sample(make_sample(500, 500, -32'sd2147483648, 32'h0000_8000));
        // A quarter-turn heading step, then full-scale velocity and rate corners.
        send_sample(make_sample(1234, -77, 32'h4000_0000, 32'h0001_8000));
        send_sample(make_sample(8388607, 8388607, 0, 32'h0002_0000));
        send_sample(make_sample(-1, -1, 32'h8000_0001, 32'h7FFF_FFFF));
        send_sample(make_sample(8388607, 8388607, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
        send_sample(make_sample(-8388608, -8388608, -1, 32'h8000_0000));
        send_sample(make_sample(0, 0, 1, 32'h8000_0001));
        // Large moves with the largest positive timestamp step, which wraps the timestamp.
        for (int i = 0; i < 8; i++)
            send_sample(make_sample(8388607, 0, 0, 32'h8000_0001 + 32'(i + 1) * 32'h7FFF_FFFF));
        clock_us = in_data.time_us;
        // Long receiver hold while the sender keeps offering.
        hold_receiver = 1;
        for (int i = 0; i < 6; i++)
            send_sample(random_sample());
        hold_receiver = 0;
        for (int n = 0; n < RANDOM_ITEMS; )
        begin
            burst = $urandom_range(1, 20);
            for (int k = 0; k < burst; k++, n++)
                send_sample(random_sample());
            if ($urandom_range(0, 2) != 0)
                idle_sender($urandom_range(1, 60));
        end
        in_valid <= 1'b0;
        sending_done = 1;
    end

    // Receiver: a stall pattern that changes over the run, plus one long hold.
    initial
    begin
        int mode;
        int hold;
        out_ready = 1'b0;
        hold_receiver = 0;
        mode = 0;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_receiver && hold == 0)
            begin
                hold = 300;
                hold_receiver = 0;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 199) == 0)
                    mode = $urandom_range(0, 2);
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Output monitor.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_pose(out_data);
    end

    // End of run: drain expectations, then wait out the latency.
    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY * 4) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end
endmodule
